// ----- design/direct_mapped_cache_core_macros.svh -----
// Assertion macros shared by the cache core.
`ifndef DIRECT_MAPPED_CACHE_CORE_MACROS_SVH
`define DIRECT_MAPPED_CACHE_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define DMC_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cache core check failed");

// Check that a condition implies another in the next cycle.
`define DMC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cache core check failed");

`endif

// ----- design/dmc_pkg.sv -----
// Shared widths, line layout and counter types for the direct-mapped cache.
package dmc_pkg;

    localparam int ADDR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int INDEX_WIDTH = 3;
    localparam int TAG_W       = ADDR_W - INDEX_WIDTH;
    localparam int LINE_COUNT  = 1 << INDEX_WIDTH;
    localparam int COUNT_W     = 32;
    localparam logic [BYTE_W-1:0] MISS_PENALTY_RESET = 8'd10;

    typedef logic [INDEX_WIDTH-1:0] index_t;
    typedef logic [TAG_W-1:0]       tag_t;

    // One stored line: tag and cached byte
    typedef struct packed {
        tag_t              tag;
        logic [BYTE_W-1:0] data;
    } line_t;

    // Counter update request from the lookup control
    typedef struct packed {
        logic              update;
        logic              hit;
        logic [BYTE_W-1:0] stall;
    } count_upd_t;

    // Counter values after the pending update
    typedef struct packed {
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] stall_total;
    } count_vals_t;

endpackage

// ----- design/direct_mapped_cache_core.sv -----
// Direct-mapped write-through, write-allocate byte cache core.
// Each access reads its line from RAM, then compares and updates it as it commits.
// Accesses do not overlap: each reads then writes the line RAM before the next is taken.
// A full output register holds the commit; input is taken again once it commits.
// Reset: all lines invalid, counters zero, miss_penalty 10; no clearing pass.
`include "direct_mapped_cache_core_macros.svh"
module direct_mapped_cache_core
    import dmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [BYTE_W-1:0]  cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [ADDR_W-1:0]  address,
    input  logic [BYTE_W-1:0]  write_data,
    input  logic [BYTE_W-1:0]  fill_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  read_data,
    output logic               hit,
    output logic [BYTE_W-1:0]  miss_stall,
    output logic               mem_write_enable,
    output logic [ADDR_W-1:0]  mem_write_address,
    output logic [BYTE_W-1:0]  mem_write_byte,
    output logic [COUNT_W-1:0] hit_total,
    output logic [COUNT_W-1:0] miss_total,
    output logic [COUNT_W-1:0] stall_total
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t              state_reg;
    logic [BYTE_W-1:0]   penalty_reg;
    logic [LINE_COUNT-1:0] valid_reg;

    logic                mode_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [BYTE_W-1:0]   wdata_reg;
    logic [BYTE_W-1:0]   fdata_reg;

    logic                in_beat;
    logic                commit;
    index_t              idx;
    tag_t                tag;
    logic                is_hit;
    logic [BYTE_W-1:0]   stall;
    line_t               rd_line;
    line_t               wr_line;
    count_upd_t          upd;
    count_vals_t         vals_next;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign commit   = (state_reg == S_READ) && (!out_valid || out_ready);

    // Decode the held access against the line read back from RAM
    always_comb
    begin
        idx     = addr_reg[INDEX_WIDTH-1:0];
        tag     = addr_reg[ADDR_W-1:INDEX_WIDTH];
        is_hit  = valid_reg[idx] && (rd_line.tag == tag);
        stall   = (is_hit || penalty_reg == '0) ? '0 : penalty_reg - 1'b1;
        wr_line.tag = tag;
        if (mode_reg)
        begin
            wr_line.data = wdata_reg;
        end
        else
        begin
            wr_line.data = is_hit ? rd_line.data : fdata_reg;
        end
        upd.update = commit;
        upd.hit    = is_hit;
        upd.stall  = stall;
    end

    dmc_line_ram #(
        .ADDR_BITS (INDEX_WIDTH),
        .DATA_BITS ($bits(line_t))
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (idx),
        .wr_data (wr_line),
        .rd_en   (in_beat),
        .rd_addr (address[INDEX_WIDTH-1:0]),
        .rd_data (rd_line)
    );

    dmc_counters u_counters (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .vals_next (vals_next)
    );

    // Hold the accepted access while its line is read
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mode_reg  <= mode;
            addr_reg  <= address;
            wdata_reg <= write_data;
            fdata_reg <= fill_data;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            penalty_reg <= MISS_PENALTY_RESET;
        end
        else if (cfg_wen)
        begin
            penalty_reg <= cfg_wdata;
        end
    end

    // Mark lines valid as they are allocated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (commit)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // Sequence state and load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= S_READ;
                    end
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                    end
                end
                S_READ:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                        out_valid <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            read_data         <= mode_reg ? '0 : wr_line.data;
            hit               <= is_hit;
            miss_stall        <= stall;
            mem_write_enable  <= mode_reg;
            mem_write_address <= mode_reg ? addr_reg : '0;
            mem_write_byte    <= mode_reg ? wdata_reg : '0;
            hit_total         <= vals_next.hit_total;
            miss_total        <= vals_next.miss_total;
            stall_total       <= vals_next.stall_total;
        end
    end

    // Checks
    `DMC_ASSERT_NEXT(a_accept_reads, in_beat, state_reg == S_READ && !in_ready)
    `DMC_ASSERT_NEXT(a_commit_shows, commit, out_valid && valid_reg[$past(idx)])
    `DMC_ASSERT_SAME(a_hit_no_stall, out_valid && hit, miss_stall == '0)
    `DMC_ASSERT_SAME(a_miss_counted, out_valid && !hit, miss_total != '0)

endmodule

// ----- design/dmc_line_ram.sv -----
// Generic single-port-write, registered-read RAM holding the cache lines.
module dmc_line_ram #(
    parameter int ADDR_BITS = 3,
    parameter int DATA_BITS = 13
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/dmc_counters.sv -----
// Saturating hit, miss and stall counters.
module dmc_counters
    import dmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  count_upd_t  upd,
    output count_vals_t vals_next
);

    logic [COUNT_W-1:0] hit_reg, miss_reg, stall_reg;
    logic [COUNT_W:0]   hit_sum, miss_sum, stall_sum;

    // Add with carry out; clamp on overflow
    always_comb
    begin
        hit_sum   = {1'b0, hit_reg} + {{COUNT_W{1'b0}}, upd.hit};
        miss_sum  = {1'b0, miss_reg} + {{COUNT_W{1'b0}}, !upd.hit};
        stall_sum = {1'b0, stall_reg} + {{(COUNT_W + 1 - BYTE_W){1'b0}}, upd.stall};
        vals_next.hit_total   = hit_sum[COUNT_W]   ? '1 : hit_sum[COUNT_W-1:0];
        vals_next.miss_total  = miss_sum[COUNT_W]  ? '1 : miss_sum[COUNT_W-1:0];
        vals_next.stall_total = stall_sum[COUNT_W] ? '1 : stall_sum[COUNT_W-1:0];
    end

    // Advance counters on each committed access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= '0;
            miss_reg  <= '0;
            stall_reg <= '0;
        end
        else if (upd.update)
        begin
            hit_reg   <= vals_next.hit_total;
            miss_reg  <= vals_next.miss_total;
            stall_reg <= vals_next.stall_total;
        end
    end

endmodule
